### rtl/iaee_pkg.sv
// Shared constants and types for the indexed array edit engine.
// Holds command and status codes, stream widths and the controller/datapath structs.
// No dependencies.
package iaee_pkg;

	// default capacity of the element store
	localparam int DEPTH_DEF = 128;

	// item field widths
	localparam int CMD_W   = 3;
	localparam int POS_W   = 8;
	localparam int DATA_W  = 32;
	localparam int ST_W    = 2;
	localparam int CNT_W   = 8;

	// stream widths, fields packed from bit 0 and padded to whole bytes
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SYMM    = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic cap;         // capture the accepted item
		logic wr_app;      // write value at the current count
		logic wr_pos;      // write value at the item position
		logic cnt_inc;
		logic cnt_dec;
		logic walk_init;   // load the shift pointer
		logic walk_up;     // shift direction at init: 1 insert, 0 delete
		logic walk_rd;     // one shift step
		logic sym_init;    // load both symmetry pointers
		logic sym_rd;      // read a mirrored pair
		logic sym_next;    // move both pointers inward
		logic rd_issue;    // read at the item position
		logic rd_take;     // latch the read word into the result
		logic set_badpos;
		logic set_full;
		logic sym_one;     // mark the array symmetric
	} iaee_ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             pos_lt_cnt;
		logic             pos_le_cnt;
		logic             pos_at_end;  // position is the last element
		logic             full;
		logic             cnt_lt2;
		logic             walk_last;
		logic             pair_eq;
		logic             pairs_done;
	} iaee_sts_t;

endpackage

### rtl/iaee_dp.sv
// Datapath of the indexed array edit engine: element memory, count, item registers,
// shift and symmetry pointers, result registers.
// Depends on iaee_pkg; driven by iaee_ctrl through iaee_ctl_t.
module iaee_dp #(
	parameter int DEPTH = iaee_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [iaee_pkg::CMD_W-1:0]      in_cmd,
	input  logic [iaee_pkg::POS_W-1:0]      in_pos,
	input  logic signed [iaee_pkg::DATA_W-1:0] in_value,
	input  iaee_pkg::iaee_ctl_t             ctl,
	output iaee_pkg::iaee_sts_t             sts,
	output logic [iaee_pkg::ST_W-1:0]       res_status,
	output logic [iaee_pkg::CNT_W-1:0]      res_count,
	output logic signed [iaee_pkg::DATA_W-1:0] res_read_value,
	output logic                            res_symmetric
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > iaee_pkg::POS_W) ? CW : iaee_pkg::POS_W;

	// element store
	logic [iaee_pkg::DATA_W-1:0] mem [DEPTH];

	// item registers
	logic [iaee_pkg::CMD_W-1:0]  cmd_q;
	logic [iaee_pkg::POS_W-1:0]  pos_q;
	logic [iaee_pkg::DATA_W-1:0] val_q;

	// count and walk state
	logic [CW-1:0]               cnt_q;
	logic [AW-1:0]               ptr_q;
	logic [AW-1:0]               hi_q;
	logic                        dir_q;
	logic [AW-1:0]               waddr_q;
	logic                        wpend_q;
	logic [iaee_pkg::DATA_W-1:0] rdat_a_q;
	logic [iaee_pkg::DATA_W-1:0] rdat_b_q;

	// result registers
	logic [iaee_pkg::ST_W-1:0]   status_q;
	logic [iaee_pkg::DATA_W-1:0] rdv_q;
	logic                        sym_q;

	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] cnt_ext;
	logic [AW-1:0]   pos_addr;
	logic [AW-1:0]   cnt_addr;
	logic [AW-1:0]   last_addr;
	logic [AW-1:0]   pair_gap;
	logic [AW-1:0]   rd_a_addr;
	logic            rd_a_en;

	// address and compare helpers
	always_comb begin
		pos_ext   = CMPW'(pos_q);
		cnt_ext   = CMPW'(cnt_q);
		pos_addr  = AW'(pos_q);
		cnt_addr  = AW'(cnt_q);
		last_addr = AW'(cnt_q - CW'(1));
		pair_gap  = hi_q - ptr_q;
		rd_a_addr = ctl.rd_issue ? pos_addr : ptr_q;
		rd_a_en   = ctl.walk_rd | ctl.sym_rd | ctl.rd_issue;
	end

	// status to the controller
	always_comb begin
		sts.cmd        = cmd_q;
		sts.pos_lt_cnt = pos_ext < cnt_ext;
		sts.pos_le_cnt = pos_ext <= cnt_ext;
		sts.pos_at_end = (pos_ext + CMPW'(1)) == cnt_ext;
		sts.full       = cnt_q == CW'(DEPTH);
		sts.cnt_lt2    = cnt_q < CW'(2);
		sts.walk_last  = dir_q ? (ptr_q == pos_addr) : (ptr_q == last_addr);
		sts.pair_eq    = rdat_a_q == rdat_b_q;
		sts.pairs_done = {1'b0, pair_gap} <= (AW + 1)'(2);
	end

	// memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wpend_q) begin
			mem[waddr_q] <= rdat_a_q;
		end else if (ctl.wr_app) begin
			mem[cnt_addr] <= val_q;
		end else if (ctl.wr_pos) begin
			mem[pos_addr] <= val_q;
		end
		if (rd_a_en) begin
			rdat_a_q <= mem[rd_a_addr];
		end
		if (ctl.sym_rd) begin
			rdat_b_q <= mem[hi_q];
		end
	end

	// count and pending shift write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			wpend_q <= 1'b0;
		end else begin
			wpend_q <= ctl.walk_rd;
			if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// item capture and result fields
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q    <= in_cmd;
			pos_q    <= in_pos;
			val_q    <= in_value;
			status_q <= iaee_pkg::ST_OK;
			rdv_q    <= '0;
			sym_q    <= 1'b0;
		end else begin
			if (ctl.set_badpos) begin
				status_q <= iaee_pkg::ST_BADPOS;
			end else if (ctl.set_full) begin
				status_q <= iaee_pkg::ST_FULL;
			end
			if (ctl.rd_take) begin
				rdv_q <= rdat_a_q;
			end
			if (ctl.sym_one) begin
				sym_q <= 1'b1;
			end
		end
	end

	// shift and symmetry pointers
	always_ff @(posedge clk) begin
		if (ctl.walk_init) begin
			dir_q <= ctl.walk_up;
			ptr_q <= ctl.walk_up ? last_addr : pos_addr + AW'(1);
		end else if (ctl.sym_init) begin
			ptr_q <= '0;
			hi_q  <= last_addr;
		end else if (ctl.walk_rd) begin
			waddr_q <= dir_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
			ptr_q   <= dir_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
		end else if (ctl.sym_next) begin
			ptr_q <= ptr_q + AW'(1);
			hi_q  <= hi_q - AW'(1);
		end
	end

	// result fields, count taken modulo 256
	assign res_status     = status_q;
	assign res_count      = iaee_pkg::CNT_W'(cnt_q);
	assign res_read_value = rdv_q;
	assign res_symmetric  = sym_q;

endmodule

### rtl/iaee_ctrl.sv
// Controller of the indexed array edit engine: one-hot state machine that decodes
// each item and sequences shifts, reads and the symmetry walk.
// Depends on iaee_pkg; drives iaee_dp through iaee_ctl_t.
module iaee_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_free,
	output logic                out_load,
	input  iaee_pkg::iaee_sts_t sts,
	output iaee_pkg::iaee_ctl_t ctl
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_EXEC  = 9'b000000010,
		S_WALK  = 9'b000000100,
		S_DRAIN = 9'b000001000,
		S_FIN   = 9'b000010000,
		S_RD    = 9'b000100000,
		S_SYR   = 9'b001000000,
		S_SYC   = 9'b010000000,
		S_DONE  = 9'b100000000
	} iaee_state_t;

	iaee_state_t state_q;
	iaee_state_t state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.cap = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (sts.cmd)
					iaee_pkg::CMD_APPEND: begin
						if (sts.full) begin
							ctl.set_full = 1'b1;
						end else begin
							ctl.wr_app  = 1'b1;
							ctl.cnt_inc = 1'b1;
						end
					end
					iaee_pkg::CMD_INSERT: begin
						priority if (!sts.pos_le_cnt) begin
							ctl.set_badpos = 1'b1;
						end else if (sts.full) begin
							ctl.set_full = 1'b1;
						end else if (sts.pos_lt_cnt) begin
							ctl.walk_init = 1'b1;
							ctl.walk_up   = 1'b1;
							state_d       = S_WALK;
						end else begin
							state_d = S_FIN;
						end
					end
					iaee_pkg::CMD_DELETE: begin
						priority if (!sts.pos_lt_cnt) begin
							ctl.set_badpos = 1'b1;
						end else if (sts.pos_at_end) begin
							state_d = S_FIN;
						end else begin
							ctl.walk_init = 1'b1;
							state_d       = S_WALK;
						end
					end
					iaee_pkg::CMD_REPLACE: begin
						if (!sts.pos_lt_cnt) begin
							ctl.set_badpos = 1'b1;
						end else begin
							ctl.wr_pos = 1'b1;
						end
					end
					iaee_pkg::CMD_READ: begin
						if (!sts.pos_lt_cnt) begin
							ctl.set_badpos = 1'b1;
						end else begin
							ctl.rd_issue = 1'b1;
							state_d      = S_RD;
						end
					end
					iaee_pkg::CMD_SYMM: begin
						if (sts.cnt_lt2) begin
							ctl.sym_one = 1'b1;
						end else begin
							ctl.sym_init = 1'b1;
							state_d      = S_SYR;
						end
					end
					default: begin
						// unused codes leave everything as is
					end
				endcase
			end
			S_WALK: begin
				ctl.walk_rd = 1'b1;
				if (sts.walk_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last shifted word is written this cycle
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.cmd == iaee_pkg::CMD_INSERT) begin
					ctl.wr_pos  = 1'b1;
					ctl.cnt_inc = 1'b1;
				end else begin
					ctl.cnt_dec = 1'b1;
				end
				state_d = S_DONE;
			end
			S_RD: begin
				ctl.rd_take = 1'b1;
				state_d     = S_DONE;
			end
			S_SYR: begin
				ctl.sym_rd = 1'b1;
				state_d    = S_SYC;
			end
			S_SYC: begin
				priority if (!sts.pair_eq) begin
					state_d = S_DONE;
				end else if (sts.pairs_done) begin
					ctl.sym_one = 1'b1;
					state_d     = S_DONE;
				end else begin
					ctl.sym_next = 1'b1;
					state_d      = S_SYR;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/indexed_array_edit_engine.sv
// Insert and delete move one element per cycle through the memory; the symmetry check
// reads one mirrored pair, then compares it before it reads the next pair.
// One item at a time: the next item is accepted once the previous result is in the
// output register. Reset clears the count to zero; element contents stay undefined.
// Depends on iaee_pkg, iaee_ctrl and iaee_dp.
module indexed_array_edit_engine #(
	parameter int DEPTH = iaee_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [iaee_pkg::IN_TDATA_W-1:0]     s_tdata,  // cmd[2:0], pos[10:3], value[42:11]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [iaee_pkg::OUT_TDATA_W-1:0]    m_tdata   // status[1:0], count[9:2],
	                                                      // read_value[41:10], symmetric[42]
);

	localparam int OUT_PAD = iaee_pkg::OUT_TDATA_W - iaee_pkg::ST_W - iaee_pkg::CNT_W
		- iaee_pkg::DATA_W - 1;

	iaee_pkg::iaee_ctl_t ctl;
	iaee_pkg::iaee_sts_t sts;

	logic [iaee_pkg::CMD_W-1:0]         in_cmd;
	logic [iaee_pkg::POS_W-1:0]         in_pos;
	logic signed [iaee_pkg::DATA_W-1:0] in_value;
	logic [iaee_pkg::ST_W-1:0]          res_status;
	logic [iaee_pkg::CNT_W-1:0]         res_count;
	logic signed [iaee_pkg::DATA_W-1:0] res_read_value;
	logic                               res_symmetric;
	logic                               out_free;
	logic                               out_load;
	logic                               m_tvalid_q;
	logic [iaee_pkg::OUT_TDATA_W-1:0]   m_tdata_q;

	// input item unpacking
	assign in_cmd   = s_tdata[2:0];
	assign in_pos   = s_tdata[10:3];
	assign in_value = s_tdata[42:11];

	iaee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.out_load (out_load),
		.sts      (sts),
		.ctl      (ctl)
	);

	iaee_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_cmd         (in_cmd),
		.in_pos         (in_pos),
		.in_value       (in_value),
		.ctl            (ctl),
		.sts            (sts),
		.res_status     (res_status),
		.res_count      (res_count),
		.res_read_value (res_read_value),
		.res_symmetric  (res_symmetric)
	);

	// output register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{OUT_PAD{1'b0}}, res_symmetric, res_read_value, res_count,
				res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// one item in flight: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while previous item still in work");

	// a full report only comes with a full array
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == iaee_pkg::ST_FULL) |->
		(m_tdata[9:2] == iaee_pkg::CNT_W'(DEPTH)))
		else $error("full status with count below capacity");

	// symmetry flag only on a clean result with no read word
	a_sym_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[42]) |->
		(m_tdata[1:0] == iaee_pkg::ST_OK && m_tdata[41:10] == '0))
		else $error("symmetry flag with nonzero status or read word");

endmodule

### verif/testbench.sv
// Self-checking testbench for the indexed array edit engine: directed table, then random episodes.
// Expected results come from a shadow copy of the array kept in the testbench.
// Depends on iaee_pkg and the indexed_array_edit_engine RTL.
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH        = iaee_pkg::DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 40;
	localparam int REPORT_MAX   = 10;

	// codes the block treats as no-ops
	localparam logic [iaee_pkg::CMD_W-1:0] CMD_NOP6 = 3'd6;
	localparam logic [iaee_pkg::CMD_W-1:0] CMD_NOP7 = 3'd7;

	typedef struct packed {
		logic [iaee_pkg::ST_W-1:0]   status;
		logic [iaee_pkg::CNT_W-1:0]  count;
		logic [iaee_pkg::DATA_W-1:0] read_value;
		logic                        symmetric;
	} array_result_t;

	typedef struct packed {
		logic [iaee_pkg::CMD_W-1:0]  cmd;
		logic [iaee_pkg::POS_W-1:0]  pos;
		logic [iaee_pkg::DATA_W-1:0] value;
		logic                        typed;
		array_result_t               res;
	} edit_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [iaee_pkg::IN_TDATA_W-1:0]  s_tdata;   // cmd[2:0], pos[10:3], value[42:11]
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [iaee_pkg::OUT_TDATA_W-1:0] m_tdata;   // status[1:0], count[9:2],
	                                             // read_value[41:10], symmetric[42]

	// shadow of the array state
	logic [iaee_pkg::DATA_W-1:0] shadow_elems [DEPTH];
	int                          shadow_count;

	array_result_t pending_results [$];
	edit_row_t     edit_rows [$];

	int  cmds_sent;
	int  results_seen = 0;
	int  fail_count = 0;
	int  report_count = 0;
	int  stall_cycles = 0;
	int  full_hits;
	int  symm_checks;
	int  symm_true;
	int  directed_count;
	logic calm;

	// no idling on either side during this window
	assign calm = (cmds_sent >= directed_count + 300) && (cmds_sent < directed_count + 450);

	indexed_array_edit_engine #(
		.DEPTH(DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #1 clk = ~clk;

	// shadow array update and expected result for one command
	function automatic array_result_t edit_array(input logic [iaee_pkg::CMD_W-1:0] c,
	                                             input logic [iaee_pkg::POS_W-1:0] p,
	                                             input logic [iaee_pkg::DATA_W-1:0] v);
		array_result_t r;
		int i;
		int lo;
		int hi;
		r = '0;
		case (c)
			iaee_pkg::CMD_APPEND: begin
				if (shadow_count >= DEPTH) begin
					r.status = iaee_pkg::ST_FULL;
				end else begin
					shadow_elems[shadow_count] = v;
					shadow_count++;
				end
			end
			iaee_pkg::CMD_INSERT: begin
				if (int'(p) > shadow_count) begin
					r.status = iaee_pkg::ST_BADPOS;
				end else if (shadow_count >= DEPTH) begin
					r.status = iaee_pkg::ST_FULL;
				end else begin
					for (i = shadow_count; i > int'(p); i--)
						shadow_elems[i] = shadow_elems[i-1];
					shadow_elems[p] = v;
					shadow_count++;
				end
			end
			iaee_pkg::CMD_DELETE: begin
				if (int'(p) >= shadow_count) begin
					r.status = iaee_pkg::ST_BADPOS;
				end else begin
					for (i = int'(p); i + 1 < shadow_count; i++)
						shadow_elems[i] = shadow_elems[i+1];
					shadow_count--;
				end
			end
			iaee_pkg::CMD_REPLACE: begin
				if (int'(p) >= shadow_count)
					r.status = iaee_pkg::ST_BADPOS;
				else
					shadow_elems[p] = v;
			end
			iaee_pkg::CMD_READ: begin
				if (int'(p) >= shadow_count)
					r.status = iaee_pkg::ST_BADPOS;
				else
					r.read_value = shadow_elems[p];
			end
			iaee_pkg::CMD_SYMM: begin
				r.symmetric = 1'b1;
				lo = 0;
				hi = shadow_count - 1;
				while (lo < hi) begin
					if (shadow_elems[lo] != shadow_elems[hi])
						r.symmetric = 1'b0;
					lo++;
					hi--;
				end
			end
			default: begin
			end
		endcase
		r.count = iaee_pkg::CNT_W'(shadow_count);
		return r;
	endfunction

	// word with a bias toward extremes and repeats
	function automatic logic [iaee_pkg::DATA_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return iaee_pkg::DATA_W'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	// position mostly within reach of the current count
	function automatic logic [iaee_pkg::POS_W-1:0] rand_pos();
		if ($urandom_range(0, 9) == 0)
			return iaee_pkg::POS_W'($urandom_range(0, 255));
		return iaee_pkg::POS_W'($urandom_range(0, shadow_count));
	endfunction

	task automatic add_row(input logic [iaee_pkg::CMD_W-1:0] c,
	                       input logic [iaee_pkg::POS_W-1:0] p,
	                       input logic [iaee_pkg::DATA_W-1:0] v, input logic typed,
	                       input logic [iaee_pkg::ST_W-1:0] st, input int cnt,
	                       input logic [iaee_pkg::DATA_W-1:0] rd, input logic sym);
		edit_row_t row;
		row.cmd = c;
		row.pos = p;
		row.value = v;
		row.typed = typed;
		row.res.status = st;
		row.res.count = iaee_pkg::CNT_W'(cnt);
		row.res.read_value = rd;
		row.res.symmetric = sym;
		edit_rows.push_back(row);
	endtask

	// drive one command item, then record what it should return
	task automatic send_cmd(input logic [iaee_pkg::CMD_W-1:0] c,
	                        input logic [iaee_pkg::POS_W-1:0] p,
	                        input logic [iaee_pkg::DATA_W-1:0] v, input logic typed,
	                        input array_result_t typed_res);
		array_result_t want;
		if (!calm && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (!calm && $urandom_range(0, 99) < 7);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, v, p, c};
		do @(posedge clk); while (!s_tready);
		want = edit_array(c, p, v);
		if (typed)
			want = typed_res;
		pending_results.push_back(want);
		cmds_sent++;
		if (want.status == iaee_pkg::ST_FULL)
			full_hits++;
		if (c == iaee_pkg::CMD_SYMM) begin
			symm_checks++;
			if (want.symmetric)
				symm_true++;
		end
	endtask

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 7);
	end

	// cycles without any accepted item or taken result
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	// result checker
	always @(posedge clk) begin
		array_result_t got;
		array_result_t want;
		if (m_tvalid && m_tready) begin
			got.status     = m_tdata[1:0];
			got.count      = m_tdata[9:2];
			got.read_value = m_tdata[41:10];
			got.symmetric  = m_tdata[42];
			results_seen++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (report_count < REPORT_MAX)
					$display("unexpected result: status %0d count %0d read %h sym %0d",
					         got.status, got.count, got.read_value, got.symmetric);
				report_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.count !== want.count ||
				    got.read_value !== want.read_value ||
				    got.symmetric !== want.symmetric) begin
					fail_count++;
					if (report_count < REPORT_MAX)
						$display({"mismatch at result %0d: exp st %0d cnt %0d rd %h sym %0d,",
						          " got st %0d cnt %0d rd %h sym %0d"},
						         results_seen, want.status, want.count, want.read_value,
						         want.symmetric, got.status, got.count, got.read_value,
						         got.symmetric);
					report_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("[indexed_array_edit_engine] ERROR");
		$finish;
	end

	initial begin
		edit_row_t row;
		int ep;
		int k;
		int half;
		int target;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		shadow_count = 0;
		cmds_sent = 0;
		full_hits = 0;
		symm_checks = 0;
		symm_true = 0;
		directed_count = 1 << 20;
		foreach (shadow_elems[k])
			shadow_elems[k] = '0;

		// directed table: empty array, extremes, every command, bad positions
		add_row(iaee_pkg::CMD_SYMM,    8'd0,   32'h0,         1, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b1);
		add_row(iaee_pkg::CMD_READ,    8'd0,   32'h0,         1, iaee_pkg::ST_BADPOS, 0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_DELETE,  8'd0,   32'h0,         1, iaee_pkg::ST_BADPOS, 0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_REPLACE, 8'd0,   32'h1234_5678, 1, iaee_pkg::ST_BADPOS, 0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_INSERT,  8'd1,   32'h1,         1, iaee_pkg::ST_BADPOS, 0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_INSERT,  8'd0,   32'h8000_0000, 1, iaee_pkg::ST_OK,     1,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_SYMM,    8'd0,   32'h0,         1, iaee_pkg::ST_OK,     1,
		        32'h0, 1'b1);
		add_row(iaee_pkg::CMD_APPEND,  8'd255, 32'h7fff_ffff, 1, iaee_pkg::ST_OK,     2,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_READ,    8'd0,   32'hffff_ffff, 1, iaee_pkg::ST_OK,     2,
		        32'h8000_0000, 1'b0);
		add_row(iaee_pkg::CMD_READ,    8'd1,   32'h0,         1, iaee_pkg::ST_OK,     2,
		        32'h7fff_ffff, 1'b0);
		add_row(iaee_pkg::CMD_SYMM,    8'd0,   32'h0,         0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_REPLACE, 8'd1,   32'h8000_0000, 0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_SYMM,    8'd255, 32'hffff_ffff, 0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_INSERT,  8'd2,   32'h0,         0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_INSERT,  8'd1,   32'hffff_ffff, 0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_READ,    8'd2,   32'h0,         0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_DELETE,  8'd3,   32'h0,         0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_DELETE,  8'd0,   32'h0,         0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(CMD_NOP6,              8'd255, 32'hffff_ffff, 0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(CMD_NOP7,              8'd0,   32'h0,         0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_READ,    8'd255, 32'h0,         1, iaee_pkg::ST_BADPOS, 2,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_READ,    8'd128, 32'h0,         1, iaee_pkg::ST_BADPOS, 2,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_INSERT,  8'd255, 32'h5,         1, iaee_pkg::ST_BADPOS, 2,
		        32'h0, 1'b0);
		add_row(iaee_pkg::CMD_READ,    8'd1,   32'h0,         0, iaee_pkg::ST_OK,     0,
		        32'h0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_count = edit_rows.size();
		foreach (edit_rows[k]) begin
			row = edit_rows[k];
			send_cmd(row.cmd, row.pos, row.value, row.typed, row.res);
		end

		// fill to capacity first, then exercise the full guard
		ep = 7;
		while (cmds_sent < directed_count + RANDOM_ITEMS) begin
			case (ep)
				0, 1, 2, 3, 4: begin
					// mixed commands
					for (k = 0; k < 20; k++)
						send_cmd(iaee_pkg::CMD_W'($urandom_range(0, 7)), rand_pos(),
						         rand_word(), 0, '0);
				end
				5, 6: begin
					// mirror the lower half, check, then maybe disturb it
					half = shadow_count / 2;
					for (k = 0; k < half; k++)
						send_cmd(iaee_pkg::CMD_REPLACE,
						         iaee_pkg::POS_W'(shadow_count - 1 - k), shadow_elems[k],
						         0, '0);
					send_cmd(iaee_pkg::CMD_SYMM, rand_pos(), rand_word(), 0, '0);
					if (shadow_count % 2 == 0 && shadow_count < DEPTH) begin
						send_cmd(iaee_pkg::CMD_INSERT, iaee_pkg::POS_W'(shadow_count / 2),
						         rand_word(), 0, '0);
						send_cmd(iaee_pkg::CMD_SYMM, rand_pos(), rand_word(), 0, '0);
					end
					if ($urandom_range(0, 1)) begin
						send_cmd(iaee_pkg::CMD_REPLACE, rand_pos(), rand_word(), 0, '0);
						send_cmd(iaee_pkg::CMD_SYMM, rand_pos(), rand_word(), 0, '0);
					end
				end
				7: begin
					// fill up and hit the full guard
					while (shadow_count < DEPTH)
						send_cmd(iaee_pkg::CMD_APPEND, iaee_pkg::POS_W'($urandom),
						         rand_word(), 0, '0);
					send_cmd(iaee_pkg::CMD_APPEND, rand_pos(), rand_word(), 0, '0);
					send_cmd(iaee_pkg::CMD_INSERT, iaee_pkg::POS_W'($urandom_range(0, DEPTH)),
					         rand_word(), 0, '0);
					send_cmd(iaee_pkg::CMD_INSERT, iaee_pkg::POS_W'(DEPTH + 1), rand_word(),
					         0, '0);
					send_cmd(iaee_pkg::CMD_READ, iaee_pkg::POS_W'(DEPTH - 1), rand_word(),
					         0, '0);
					send_cmd(iaee_pkg::CMD_READ, iaee_pkg::POS_W'(DEPTH), rand_word(), 0, '0);
					send_cmd(iaee_pkg::CMD_SYMM, rand_pos(), rand_word(), 0, '0);
				end
				default: begin
					// drain down to a short array
					target = $urandom_range(0, 3);
					while (shadow_count > target)
						send_cmd(iaee_pkg::CMD_DELETE,
						         iaee_pkg::POS_W'($urandom_range(0, shadow_count - 1)),
						         rand_word(), 0, '0);
					send_cmd(iaee_pkg::CMD_SYMM, rand_pos(), rand_word(), 0, '0);
					send_cmd(iaee_pkg::CMD_READ, 8'd0, rand_word(), 0, '0);
				end
			endcase
			ep = $urandom_range(0, 9);
		end
		s_tvalid <= 1'b0;

		// wait for outstanding results, then let the block settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d commands (%0d from the table), checked %0d results",
		         cmds_sent, directed_count, results_seen);
		$display("full-array refusals %0d, symmetry checks %0d of which %0d true",
		         full_hits, symm_checks, symm_true);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("[indexed_array_edit_engine] OK");
		else
			$display("[indexed_array_edit_engine] ERROR");
		$finish;
	end

endmodule
